// File: rtl/scp_pkg.sv
// Shared constants, types and controller codes of the sector cache clock replacement engine.
package scp_pkg;

   localparam int NUM_SLOTS  = 64;
   localparam int LANES      = 8;
   localparam int LANE_W     = $clog2(LANES);
   localparam int ROWS       = (NUM_SLOTS + LANES - 1) / LANES;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_W     = ROW_W + LANE_W;
   localparam int SLOT_DEPTH = 1 << SLOT_W;
   localparam int TAG_W      = 32;
   localparam int CHANCE_W   = 4;
   localparam int IDX_OUT_W  = 6;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [CHANCE_W-1:0] CHANCE_RESET = CHANCE_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SWEEP_RD,
      ST_SWEEP,
      ST_VICT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic look;
      logic sweep_start;
      logic sweep;
      logic install;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic last_row;
      logic stop;
      logic out_free;
   } status_type;

endpackage

// File: rtl/scp_ctrl.sv
// Controller state machine: sequences tag scan, clock sweep, install and result hand-off.
module scp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  scp_pkg::status_type status,
   output scp_pkg::cmd_type    cmd
);

   scp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scp_pkg::ST_IDLE: begin
            if (req_valid) state_in = scp_pkg::ST_LOOK;
         end
         scp_pkg::ST_LOOK: begin
            if (status.match) state_in = scp_pkg::ST_OUT;
            else if (status.last_row) state_in = scp_pkg::ST_SWEEP_RD;
         end
         scp_pkg::ST_SWEEP_RD: state_in = scp_pkg::ST_SWEEP;
         scp_pkg::ST_SWEEP: begin
            if (status.stop) state_in = scp_pkg::ST_VICT;
         end
         scp_pkg::ST_VICT: state_in = scp_pkg::ST_OUT;
         scp_pkg::ST_OUT: begin
            if (status.out_free) state_in = scp_pkg::ST_IDLE;
         end
         default: state_in = scp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         scp_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         scp_pkg::ST_LOOK:     cmd.look        = 1'b1;
         scp_pkg::ST_SWEEP_RD: cmd.sweep_start = 1'b1;
         scp_pkg::ST_SWEEP:    cmd.sweep       = 1'b1;
         scp_pkg::ST_VICT:     cmd.install     = 1'b1;
         scp_pkg::ST_OUT:      cmd.out_load    = status.out_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/scp_dpath.sv
// Datapath: banked tag store, valid bits, chance and dirty stores, clock hand and result registers.
module scp_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  scp_pkg::cmd_type                     cmd,
   output scp_pkg::status_type                  status,
   input  logic                                 req_type,
   input  logic [scp_pkg::TAG_W-1:0]            req_sector_number,
   input  logic                                 csr_valid,
   input  logic [scp_pkg::CHANCE_W-1:0]         csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [scp_pkg::IDX_OUT_W-1:0]        rsp_slot_index,
   output logic                                 rsp_write_back,
   output logic [scp_pkg::TAG_W-1:0]            rsp_victim_sector,
   output logic                                 rsp_fill
);

   logic [scp_pkg::TAG_W-1:0]    tag_mem [scp_pkg::LANES][scp_pkg::ROWS];
   logic [scp_pkg::CHANCE_W-1:0] chance_mem [scp_pkg::SLOT_DEPTH];
   logic                         dirty_mem [scp_pkg::SLOT_DEPTH];

   logic [scp_pkg::SLOT_DEPTH-1:0] valid_ff, valid_in;
   logic [scp_pkg::TAG_W-1:0]      tag_q_ff [scp_pkg::LANES];
   logic [scp_pkg::CHANCE_W-1:0]   chance_q_ff;
   logic                           dirty_q_ff;

   logic [scp_pkg::CHANCE_W-1:0] refill_ff;
   logic [scp_pkg::TAG_W-1:0]    sector_ff;
   logic                         write_ff;
   logic [scp_pkg::ROW_W-1:0]    cmp_row_ff, cmp_row_in;
   logic [scp_pkg::SLOT_W-1:0]   hand_ff, hand_in;

   logic                         hold_hit_ff;
   logic [scp_pkg::SLOT_W-1:0]   hold_idx_ff;
   logic                         hold_wb_ff;
   logic [scp_pkg::TAG_W-1:0]    hold_vs_ff;
   logic                         hold_fill_ff;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [scp_pkg::ROW_W-1:0]    next_row;
   logic [scp_pkg::ROW_W-1:0]    tag_rd_row;
   logic [scp_pkg::SLOT_W-1:0]   hand_next;
   logic [scp_pkg::ROW_W-1:0]    hand_row;
   logic [scp_pkg::LANE_W-1:0]   hand_lane;
   logic                         match;
   logic [scp_pkg::LANE_W-1:0]   match_lane;
   logic [scp_pkg::SLOT_W-1:0]   match_idx;
   logic                         stop;
   logic                         wb;
   logic                         hit_upd;
   logic                         dec_upd;
   logic                         ch_we;
   logic [scp_pkg::SLOT_W-1:0]   ch_wa;
   logic [scp_pkg::CHANCE_W-1:0] ch_wd;
   logic                         dt_we;
   logic [scp_pkg::SLOT_W-1:0]   dt_wa;
   logic                         dt_wd;

   assign hand_row  = hand_ff[scp_pkg::SLOT_W-1:scp_pkg::LANE_W];
   assign hand_lane = hand_ff[scp_pkg::LANE_W-1:0];
   assign hand_next = (hand_ff == scp_pkg::LAST_SLOT) ? '0 : hand_ff + 1'b1;
   assign next_row  = (cmp_row_ff == scp_pkg::LAST_ROW) ? '0 : cmp_row_ff + 1'b1;

   // Compare one row of all lanes; the lowest lane wins.
   always_comb begin
      match      = 1'b0;
      match_lane = '0;
      for (int l = scp_pkg::LANES - 1; l >= 0; l--) begin
         if (valid_ff[{cmp_row_ff, scp_pkg::LANE_W'(l)}] && tag_q_ff[l] == sector_ff) begin
            match      = 1'b1;
            match_lane = scp_pkg::LANE_W'(l);
         end
      end
   end
   assign match_idx = {cmp_row_ff, match_lane};

   assign stop    = !valid_ff[hand_ff] || chance_q_ff == '0;
   assign wb      = valid_ff[hand_ff] && dirty_q_ff;
   assign hit_upd = cmd.look && match;
   assign dec_upd = cmd.sweep && !stop;

   assign status.match    = match;
   assign status.last_row = cmp_row_ff == scp_pkg::LAST_ROW;
   assign status.stop     = stop;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.load_req) tag_rd_row = '0;
      else if (cmd.look) tag_rd_row = next_row;
      else tag_rd_row = hand_row;
   end

   always_comb begin
      cmp_row_in = cmp_row_ff;
      if (cmd.load_req) cmp_row_in = '0;
      else if (cmd.look) cmp_row_in = next_row;
   end

   always_comb begin
      hand_in = hand_ff;
      if (cmd.sweep_start || dec_upd) hand_in = hand_next;
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.install) valid_in[hand_ff] = 1'b1;
   end

   always_comb begin
      ch_we = hit_upd || dec_upd || cmd.install;
      ch_wa = hit_upd ? match_idx : hand_ff;
      ch_wd = dec_upd ? chance_q_ff - 1'b1 : refill_ff;
      dt_we = (hit_upd && write_ff) || cmd.install;
      dt_wa = hit_upd ? match_idx : hand_ff;
      dt_wd = write_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         hand_ff      <= '0;
         refill_ff    <= scp_pkg::CHANCE_RESET;
         rsp_valid_ff <= 1'b0;
         cmp_row_ff   <= '0;
      end else begin
         valid_ff     <= valid_in;
         hand_ff      <= hand_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_row_ff   <= cmp_row_in;
         if (csr_valid) refill_ff <= csr_data;
      end
   end

   // Stores: registered reads, one write port each.
   always_ff @(posedge clock) begin
      for (int l = 0; l < scp_pkg::LANES; l++) begin
         tag_q_ff[l] <= tag_mem[l][tag_rd_row];
      end
      if (cmd.install) tag_mem[hand_lane][hand_row] <= sector_ff;
      chance_q_ff <= chance_mem[hand_next];
      if (ch_we) chance_mem[ch_wa] <= ch_wd;
      dirty_q_ff <= dirty_mem[hand_ff];
      if (dt_we) dirty_mem[dt_wa] <= dt_wd;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         sector_ff <= req_sector_number;
         write_ff  <= req_type;
      end
      if (hit_upd) begin
         hold_hit_ff  <= 1'b1;
         hold_idx_ff  <= match_idx;
         hold_wb_ff   <= 1'b0;
         hold_vs_ff   <= '0;
         hold_fill_ff <= 1'b0;
      end else if (cmd.install) begin
         hold_hit_ff  <= 1'b0;
         hold_idx_ff  <= hand_ff;
         hold_wb_ff   <= wb;
         hold_vs_ff   <= wb ? tag_q_ff[hand_lane] : '0;
         hold_fill_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         rsp_hit           <= hold_hit_ff;
         rsp_slot_index    <= scp_pkg::IDX_OUT_W'(hold_idx_ff);
         rsp_write_back    <= hold_wb_ff;
         rsp_victim_sector <= hold_vs_ff;
         rsp_fill          <= hold_fill_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/sector_cache_clock_replacement.sv
// Hit in tag row r (eight slots a row): the scan compares rows 0 to r, then loads the result.
// Miss: full tag scan of eight rows for 64 slots, then sweep start, a clock sweep over
// the slots the hand visits, victim read, install and output; one item in flight at a time.
// Tag scan rate is set by eight tag banks read one row a cycle; the sweep by one chance read.
// The next word is taken while a result word still waits in the output register.
// Synchronous reset: all slots empty, hand at slot zero, chance refill 1; no clearing pass.
module sector_cache_clock_replacement (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [scp_pkg::TAG_W-1:0]     req_sector_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [scp_pkg::IDX_OUT_W-1:0] rsp_slot_index,
   output logic                          rsp_write_back,
   output logic [scp_pkg::TAG_W-1:0]     rsp_victim_sector,
   output logic                          rsp_fill,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [scp_pkg::CHANCE_W-1:0]  csr_data
);

   scp_pkg::cmd_type    cmd;
   scp_pkg::status_type status;

   assign csr_ready = 1'b1;

   scp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   scp_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_sector_number (req_sector_number),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_write_back    (rsp_write_back),
      .rsp_victim_sector (rsp_victim_sector),
      .rsp_fill          (rsp_fill)
   );

endmodule
